// ===== hw/rtl/point_line_distance_assert.svh =====
// ----------------------------------------------------------------------------
// point_line_distance_assert
// assertion macros used by the port checker of the point to line distance block
// ----------------------------------------------------------------------------
`ifndef POINT_LINE_DISTANCE_ASSERT_SVH
`define POINT_LINE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define PLD_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pld_pkg.sv =====
// ----------------------------------------------------------------------------
// pld_pkg
// widths, register indexes and the queued request type of the distance block
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned VecW     = CoordW + 1;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned MagW     = ProdW + 1;
  localparam int unsigned SqW      = 2 * MagW - 1;
  localparam int unsigned NumW     = SqW + 2;
  localparam int unsigned DirSqW   = 2 * CoordW - 1;
  localparam int unsigned DdW      = 2 * CoordW;
  localparam int unsigned DistW    = 17;
  localparam int unsigned QuoW     = 2 * DistW;
  localparam int unsigned HiW      = NumW - QuoW;
  localparam int unsigned RootRemW = DistW + 2;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegBaseX = 3'd0;
  localparam logic [RegIdxW-1:0] RegBaseY = 3'd1;
  localparam logic [RegIdxW-1:0] RegBaseZ = 3'd2;
  localparam logic [RegIdxW-1:0] RegDirX  = 3'd3;
  localparam logic [RegIdxW-1:0] RegDirY  = 3'd4;
  localparam logic [RegIdxW-1:0] RegDirZ  = 3'd5;

  typedef struct packed {
    logic signed [VecW-1:0]   v_x;
    logic signed [VecW-1:0]   v_y;
    logic signed [VecW-1:0]   v_z;
    logic signed [CoordW-1:0] d_x;
    logic signed [CoordW-1:0] d_y;
    logic signed [CoordW-1:0] d_z;
    logic                     degenerate;
  } req_t;

endpackage

// ===== hw/rtl/pld_front.sv =====
// ----------------------------------------------------------------------------
// pld_front
// line registers and request capture
// ----------------------------------------------------------------------------
module pld_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pld_pkg::RegIdxW-1:0]          cfg_idx_i,
  input  logic [pld_pkg::CoordW-1:0]           cfg_wdata_i,
  input  logic                                 accept_i,
  input  logic signed [pld_pkg::CoordW-1:0]    query_x_i,
  input  logic signed [pld_pkg::CoordW-1:0]    query_y_i,
  input  logic signed [pld_pkg::CoordW-1:0]    query_z_i,
  input  logic                                 taken_i,
  output logic                                 req_vld_o,
  output pld_pkg::req_t                        req_o
);

  logic signed [pld_pkg::CoordW-1:0] regs_q [pld_pkg::NumRegs];
  logic                              vld_q, vld_d;
  pld_pkg::req_t                     req_q, req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(pld_pkg::NumRegs); i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= pld_pkg::RegDirZ)) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    req_d            = req_q;
    req_d.v_x        = pld_pkg::VecW'(query_x_i) - pld_pkg::VecW'(regs_q[pld_pkg::RegBaseX]);
    req_d.v_y        = pld_pkg::VecW'(query_y_i) - pld_pkg::VecW'(regs_q[pld_pkg::RegBaseY]);
    req_d.v_z        = pld_pkg::VecW'(query_z_i) - pld_pkg::VecW'(regs_q[pld_pkg::RegBaseZ]);
    req_d.d_x        = regs_q[pld_pkg::RegDirX];
    req_d.d_y        = regs_q[pld_pkg::RegDirY];
    req_d.d_z        = regs_q[pld_pkg::RegDirZ];
    req_d.degenerate = (regs_q[pld_pkg::RegDirX] == '0) && (regs_q[pld_pkg::RegDirY] == '0)
                       && (regs_q[pld_pkg::RegDirZ] == '0);
    vld_d            = accept_i | (vld_q & ~taken_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_d;
    end
  end

  assign req_vld_o = vld_q;
  assign req_o     = req_q;

endmodule

// ===== hw/rtl/pld_queue.sv =====
// ----------------------------------------------------------------------------
// pld_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module pld_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pld_pkg::req_t push_req_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          pop_vld_o,
  output pld_pkg::req_t pop_req_o
);

  pld_pkg::req_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign pop_vld_o = (cnt_q != 2'd0);
  assign pop_req_o = mem_q[rptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & pop_vld_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_q ^ do_push;
      rptr_q <= rptr_q ^ do_pop;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_req_i;
    end
  end

endmodule

// ===== hw/rtl/pld_back.sv =====
// ----------------------------------------------------------------------------
// pld_back
// cross product, squared norm, pipelined divider and square root
// ----------------------------------------------------------------------------
module pld_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_vld_i,
  input  pld_pkg::req_t                req_i,
  output logic                         valid_o,
  output logic [pld_pkg::DistW-1:0]    distance_o,
  output logic                         degenerate_o
);

  localparam int unsigned QW = pld_pkg::QuoW;
  localparam int unsigned RW = pld_pkg::DistW;

  // front of the arithmetic
  logic                               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic                               s1_deg_q, s2_deg_q, s3_deg_q, s4_deg_q;
  logic [pld_pkg::DirSqW-1:0]         dsq_q [3];
  logic [pld_pkg::DdW-1:0]            s2_dd_q, s3_dd_q, s4_dd_q;
  logic signed [pld_pkg::ProdW-1:0]   prod_q [6];
  logic signed [pld_pkg::MagW-1:0]    diff_d [3];
  logic [pld_pkg::MagW-1:0]           mag_q [3];
  logic [pld_pkg::SqW-1:0]            sq_q [3];
  logic [pld_pkg::NumW-1:0]           num_q;
  logic [pld_pkg::HiW-1:0]            num_hi;

  // divider stages
  logic                               dv_vld_q [QW+1];
  logic                               dv_deg_q [QW+1];
  logic                               dv_ovf_q [QW+1];
  logic [pld_pkg::DdW-1:0]            dv_dd_q  [QW+1];
  logic [pld_pkg::DdW-1:0]            dv_rem_q [QW+1];
  logic [QW-1:0]                      dv_low_q [QW+1];
  logic [QW-1:0]                      dv_quo_q [QW+1];

  // root stages, entry zero is the divider output
  logic                               rt_vld [RW+1];
  logic                               rt_deg [RW+1];
  logic                               rt_ovf [RW+1];
  logic [pld_pkg::RootRemW-1:0]       rt_rem [RW+1];
  logic [RW-1:0]                      rt_root [RW+1];
  logic [QW-1:0]                      rt_x [RW+1];

  logic                               out_vld_q;
  logic                               out_deg_q;
  logic [RW-1:0]                      out_dist_q;

  always_comb begin
    diff_d[0] = pld_pkg::MagW'(prod_q[0]) - pld_pkg::MagW'(prod_q[1]);
    diff_d[1] = pld_pkg::MagW'(prod_q[2]) - pld_pkg::MagW'(prod_q[3]);
    diff_d[2] = pld_pkg::MagW'(prod_q[4]) - pld_pkg::MagW'(prod_q[5]);
  end

  assign num_hi = num_q[pld_pkg::NumW-1:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= pld_pkg::ProdW'(req_i.v_y * req_i.d_z);
    prod_q[1] <= pld_pkg::ProdW'(req_i.v_z * req_i.d_y);
    prod_q[2] <= pld_pkg::ProdW'(req_i.v_z * req_i.d_x);
    prod_q[3] <= pld_pkg::ProdW'(req_i.v_x * req_i.d_z);
    prod_q[4] <= pld_pkg::ProdW'(req_i.v_x * req_i.d_y);
    prod_q[5] <= pld_pkg::ProdW'(req_i.v_y * req_i.d_x);
    dsq_q[0]  <= pld_pkg::DirSqW'(req_i.d_x * req_i.d_x);
    dsq_q[1]  <= pld_pkg::DirSqW'(req_i.d_y * req_i.d_y);
    dsq_q[2]  <= pld_pkg::DirSqW'(req_i.d_z * req_i.d_z);
    s1_deg_q  <= req_i.degenerate;
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= diff_d[i][pld_pkg::MagW-1] ? pld_pkg::MagW'(-diff_d[i])
                                              : pld_pkg::MagW'(diff_d[i]);
      sq_q[i]  <= pld_pkg::SqW'(mag_q[i]) * pld_pkg::SqW'(mag_q[i]);
    end
    s2_deg_q <= s1_deg_q;
    s2_dd_q  <= pld_pkg::DdW'(dsq_q[0]) + pld_pkg::DdW'(dsq_q[1]) + pld_pkg::DdW'(dsq_q[2]);
    s3_deg_q <= s2_deg_q;
    s3_dd_q  <= s2_dd_q;
    num_q    <= pld_pkg::NumW'(sq_q[0]) + pld_pkg::NumW'(sq_q[1]) + pld_pkg::NumW'(sq_q[2]);
    s4_deg_q <= s3_deg_q;
    s4_dd_q  <= s3_dd_q;
  end

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= int'(QW); k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else begin
      dv_vld_q[0] <= s4_vld_q;
      for (int k = 0; k < int'(QW); k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_deg_q[0] <= s4_deg_q;
    dv_dd_q[0]  <= s4_dd_q;
    dv_ovf_q[0] <= (num_hi >= pld_pkg::HiW'(s4_dd_q));
    dv_rem_q[0] <= num_hi[pld_pkg::DdW-1:0];
    dv_low_q[0] <= num_q[QW-1:0];
    dv_quo_q[0] <= '0;
    for (int k = 0; k < int'(QW); k++) begin
      logic [pld_pkg::DdW:0] t;
      logic                  ge;
      t  = {dv_rem_q[k], dv_low_q[k][QW-1]};
      ge = (t >= {1'b0, dv_dd_q[k]});
      dv_rem_q[k+1] <= ge ? pld_pkg::DdW'(t - {1'b0, dv_dd_q[k]}) : t[pld_pkg::DdW-1:0];
      dv_low_q[k+1] <= {dv_low_q[k][QW-2:0], 1'b0};
      dv_quo_q[k+1] <= {dv_quo_q[k][QW-2:0], ge};
      dv_deg_q[k+1] <= dv_deg_q[k];
      dv_ovf_q[k+1] <= dv_ovf_q[k];
      dv_dd_q[k+1]  <= dv_dd_q[k];
    end
  end

  assign rt_vld[0]  = dv_vld_q[QW];
  assign rt_deg[0]  = dv_deg_q[QW];
  assign rt_ovf[0]  = dv_ovf_q[QW];
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_x[0]    = dv_quo_q[QW];

  // digit-by-digit square root, one root bit per stage
  for (genvar j = 0; j < int'(RW); j++) begin : g_root
    logic [pld_pkg::RootRemW+1:0] t;
    logic [pld_pkg::RootRemW+1:0] trial;
    logic                         ge;
    logic                         vld_q;

    always_comb begin
      t     = {rt_rem[j], rt_x[j][QW-1:QW-2]};
      trial = (pld_pkg::RootRemW+2)'({rt_root[j], 2'b01});
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= rt_vld[j];
      end
    end

    logic                         deg_q, ovf_q;
    logic [pld_pkg::RootRemW-1:0] rem_q;
    logic [RW-1:0]                root_q;
    logic [QW-1:0]                x_q;

    always_ff @(posedge clk_i) begin
      deg_q  <= rt_deg[j];
      ovf_q  <= rt_ovf[j];
      rem_q  <= ge ? pld_pkg::RootRemW'(t - trial) : t[pld_pkg::RootRemW-1:0];
      root_q <= {rt_root[j][RW-2:0], ge};
      x_q    <= {rt_x[j][QW-3:0], 2'b00};
    end

    assign rt_vld[j+1]  = vld_q;
    assign rt_deg[j+1]  = deg_q;
    assign rt_ovf[j+1]  = ovf_q;
    assign rt_rem[j+1]  = rem_q;
    assign rt_root[j+1] = root_q;
    assign rt_x[j+1]    = x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= rt_vld[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_deg_q <= rt_deg[RW];
    if (rt_deg[RW]) begin
      out_dist_q <= '0;
    end else if (rt_ovf[RW]) begin
      out_dist_q <= '1;
    end else begin
      out_dist_q <= rt_root[RW];
    end
  end

  assign valid_o      = out_vld_q;
  assign distance_o   = out_dist_q;
  assign degenerate_o = out_deg_q;

endmodule

// ===== hw/rtl/point_line_distance.sv =====
// ----------------------------------------------------------------------------
// point_line_distance
// Distance from a query point to a line held in the base and direction
// registers. A new request is taken in every cycle in which start is high and
// busy is low; the result strobe valid_o follows through the back pipeline:
// four arithmetic stages, 34 divider stages producing one quotient bit each
// and 17 square root stages producing one root bit each.
// busy is low in normal operation since the back never stalls. A register
// write applies to every request taken after the write.
// ----------------------------------------------------------------------------
module point_line_distance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pld_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [pld_pkg::CoordW-1:0]        cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pld_pkg::CoordW-1:0] query_x_i,
  input  logic signed [pld_pkg::CoordW-1:0] query_y_i,
  input  logic signed [pld_pkg::CoordW-1:0] query_z_i,
  output logic                              valid_o,
  output logic [pld_pkg::DistW-1:0]         distance_o,
  output logic                              degenerate_o
);

  logic          front_vld;
  pld_pkg::req_t front_req;
  logic          q_full;
  logic          q_vld;
  pld_pkg::req_t q_req;
  logic          accept;

  assign busy   = front_vld & q_full;
  assign accept = start & ~busy;

  pld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .query_x_i   (query_x_i),
    .query_y_i   (query_y_i),
    .query_z_i   (query_z_i),
    .taken_i     (~q_full),
    .req_vld_o   (front_vld),
    .req_o       (front_req)
  );

  pld_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_vld),
    .push_req_i (front_req),
    .pop_i      (1'b1),
    .full_o     (q_full),
    .pop_vld_o  (q_vld),
    .pop_req_o  (q_req)
  );

  pld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_vld_i    (q_vld),
    .req_i        (q_req),
    .valid_o      (valid_o),
    .distance_o   (distance_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ===== hw/rtl/pld_checker.sv =====
// ----------------------------------------------------------------------------
// pld_port_checker
// port-level checks of the distance block, bound to the top level
// ----------------------------------------------------------------------------
`include "point_line_distance_assert.svh"

module pld_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          valid_o,
  input logic [pld_pkg::DistW-1:0]     distance_o,
  input logic                          degenerate_o
);

  `PLD_ASSERT(a_degenerate_zero, clk_i, rst_ni, valid_o && degenerate_o, distance_o == '0, "degenerate result with nonzero distance")
  `PLD_ASSERT(a_busy_cause, clk_i, rst_ni, busy, $past(start || busy), "busy without a pending request")
  `PLD_ASSERT(a_no_strobe_at_release, clk_i, rst_ni, $rose(rst_ni), !valid_o, "result strobe straight after reset")

endmodule

bind point_line_distance pld_port_checker u_pld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .distance_o   (distance_o),
  .degenerate_o (degenerate_o)
);

// ===== verif/pld_checker.sv =====
// ----------------------------------------------------------------------------
// pld_checker
// watches requests and results of the point to line distance block, keeps its
// own copy of the line registers, predicts each distance and compares in order
// ----------------------------------------------------------------------------
module pld_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pld_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [pld_pkg::CoordW-1:0]        cfg_wdata_i,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [pld_pkg::CoordW-1:0] query_x_i,
  input  logic signed [pld_pkg::CoordW-1:0] query_y_i,
  input  logic signed [pld_pkg::CoordW-1:0] query_z_i,
  input  logic                              valid_o,
  input  logic [pld_pkg::DistW-1:0]         distance_o,
  input  logic                              degenerate_o,
  output int                                fail_cnt_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pld_pkg::DistW-1:0] dist_val;
    logic                      degen;
  } dist_res_t;

  logic signed [pld_pkg::CoordW-1:0] line_q [pld_pkg::NumRegs];
  dist_res_t                         dist_q [$];

  function automatic dist_res_t predict_distance(logic signed [pld_pkg::CoordW-1:0] px,
                                                 logic signed [pld_pkg::CoordW-1:0] py,
                                                 logic signed [pld_pkg::CoordW-1:0] pz);
    logic signed [63:0] vx, vy, vz, dx, dy, dz;
    logic signed [63:0] cx, cy, cz;
    logic [127:0]       num, quo, t;
    logic [63:0]        dd;
    logic [35:0]        root;
    dist_res_t          r;
    vx = 64'(px) - 64'(line_q[pld_pkg::RegBaseX]);
    vy = 64'(py) - 64'(line_q[pld_pkg::RegBaseY]);
    vz = 64'(pz) - 64'(line_q[pld_pkg::RegBaseZ]);
    dx = line_q[pld_pkg::RegDirX];
    dy = line_q[pld_pkg::RegDirY];
    dz = line_q[pld_pkg::RegDirZ];
    dd = dx * dx + dy * dy + dz * dz;
    r  = '0;
    if (dd == 0) begin
      r.degen = 1'b1;
      return r;
    end
    cx  = vy * dz - vz * dy;
    cy  = vz * dx - vx * dz;
    cz  = vx * dy - vy * dx;
    num = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
    quo = num / 128'(dd);
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      t = 128'(root | (36'd1 << b));
      if (t * t <= quo) root = root | (36'd1 << b);
    end
    r.dist_val = (root > 36'h1FFFF) ? 17'h1FFFF : root[pld_pkg::DistW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("pld_checker: mismatch at %0t: %s", $time, what);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dist_res_t e;
    if (!rst_ni) begin
      foreach (line_q[i]) line_q[i] = '0;
      dist_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (valid_o) begin
        if (dist_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result distance=%0d", distance_o));
        end else begin
          e = dist_q.pop_front();
          if (distance_o !== e.dist_val)
            report_mismatch($sformatf("distance %0d exp %0d", distance_o, e.dist_val));
          if (degenerate_o !== e.degen)
            report_mismatch($sformatf("degenerate %0b exp %0b", degenerate_o, e.degen));
        end
      end
      if (start && !busy)
        dist_q.push_back(predict_distance(query_x_i, query_y_i, query_z_i));
      if (cfg_we_i && cfg_idx_i < pld_pkg::NumRegs)
        line_q[cfg_idx_i] = cfg_wdata_i;
      pending_o = dist_q.size();
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives query points through the distance block under several line settings,
// with random start gaps, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 2000;
  localparam int Latency    = 70;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [pld_pkg::RegIdxW-1:0]       cfg_idx_i = '0;
  logic [pld_pkg::CoordW-1:0]        cfg_wdata_i = '0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [pld_pkg::CoordW-1:0] query_x_i = '0, query_y_i = '0, query_z_i = '0;
  logic                              valid_o;
  logic [pld_pkg::DistW-1:0]         distance_o;
  logic                              degenerate_o;
  int                                fail_cnt, pending;
  int                                gap_pct = 7;
  int                                quiet_cnt = 0;

  always #1 clk_i = ~clk_i;

  point_line_distance u_dut (.*);

  pld_checker u_chk (
    .*,
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || cfg_we_i) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WatchLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_line(logic [pld_pkg::RegIdxW-1:0] idx,
                            logic [pld_pkg::CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_line(logic [pld_pkg::CoordW-1:0] bx, by, bz, dx, dy, dz);
    while (pending != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    write_line(pld_pkg::RegBaseX, bx);
    write_line(pld_pkg::RegBaseY, by);
    write_line(pld_pkg::RegBaseZ, bz);
    write_line(pld_pkg::RegDirX, dx);
    write_line(pld_pkg::RegDirY, dy);
    write_line(pld_pkg::RegDirZ, dz);
    // unknown index is ignored
    write_line(3'd7, 16'($urandom));
    repeat (4) @(negedge clk_i);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_point(logic [pld_pkg::CoordW-1:0] px, py, pz);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    query_x_i <= px;
    query_y_i <= py;
    query_z_i <= pz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [pld_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(4, 0))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(512, 0)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    start <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    // reset line: zero direction, degenerate
    send_point(16'h7FFF, 16'h8000, 16'h0100);
    start <= 1'b0;
    set_line(16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0);
    send_point(16'h0, 16'h0100, 16'h0);
    send_point(16'h0500, 16'h0, 16'h0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    start <= 1'b0;
    set_line(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h0, 16'h0, 16'h0);
    send_point(16'hFFFF, 16'h0001, 16'hFFFF);
    start <= 1'b0;
    set_line(16'h8000, 16'h7FFF, 16'h0, 16'h0001, 16'h0, 16'h7FFF);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h5555, 16'hAAAA, 16'h5555);
    send_point(16'hAAAA, 16'h5555, 16'hAAAA);
    start <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 7 : (ph == 1) ? 64 : 0;
      for (int s = 0; s < 4; s++) begin
        if (s == 3) set_line(rand_coord(), rand_coord(), rand_coord(),
                             16'h0, 16'h0, 16'h0);
        else set_line(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        random_points(100);
      end
    end
    while (pending != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    if (fail_cnt == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
